// ===== src/ts_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ts_pkg;

	localparam int SAMPLE_BITS = 24;
	localparam int COEFF_BITS  = 16;
	localparam int GAIN_BITS   = 16;
	localparam int GAIN_FRAC   = 12;
	localparam int FLOOR_BITS  = SAMPLE_BITS - 1;
	localparam int LEVEL_BITS  = 32;
	localparam int LEVEL_SHIFT = LEVEL_BITS - SAMPLE_BITS;
	localparam int MUL_A_BITS  = LEVEL_BITS + 1;
	localparam int MUL_B_BITS  = (COEFF_BITS > GAIN_BITS) ? COEFF_BITS : GAIN_BITS;
	localparam int PROD_BITS   = MUL_A_BITS + MUL_B_BITS + 1;

	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 32;

	localparam logic [CFG_INDEX_BITS-1:0] REG_TRANSIENT_GAIN = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_STEADY_GAIN    = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_FAST_RISE      = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_FAST_FALL      = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SLOW_SMOOTH    = 3'd4;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SILENCE_FLR    = 3'd5;

	localparam logic [GAIN_BITS-1:0]  GAIN_UNITY  = GAIN_BITS'(1 << GAIN_FRAC);
	localparam logic [FLOOR_BITS-1:0] FLOOR_RESET = FLOOR_BITS'(8);

	localparam int PC_BITS = 3;

	localparam logic [PC_BITS-1:0] STEP_EMIT_PASS = 3'd7;

	typedef enum logic [1:0] {
		MUL_NONE,
		MUL_FAST,
		MUL_SLOW,
		MUL_GAIN
	} mul_sel_t;

	typedef enum logic [1:0] {
		UPD_NONE,
		UPD_FAST,
		UPD_SLOW
	} upd_sel_t;

	typedef enum logic [1:0] {
		EMIT_NONE,
		EMIT_GAIN,
		EMIT_PASS
	} emit_sel_t;

	typedef struct packed {
		mul_sel_t           mul;
		upd_sel_t           upd;
		logic               decide;
		logic               jmp_quiet;
		logic [PC_BITS-1:0] target;
		emit_sel_t          emit;
	} ucode_t;

	typedef struct packed {
		logic      load;
		mul_sel_t  mul;
		upd_sel_t  upd;
		logic      decide;
		emit_sel_t emit;
	} dp_ctrl_t;

	typedef struct packed {
		logic [GAIN_BITS-1:0]  transient_gain;
		logic [GAIN_BITS-1:0]  steady_gain;
		logic [COEFF_BITS-1:0] fast_rise_coeff;
		logic [COEFF_BITS-1:0] fast_fall_coeff;
		logic [COEFF_BITS-1:0] slow_smooth_coeff;
		logic [FLOOR_BITS-1:0] silence_floor;
	} cfg_t;

endpackage

`default_nettype wire

// ===== src/ts_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ts_regs (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               wr_en,
	input  wire logic [ts_pkg::CFG_INDEX_BITS-1:0]  wr_index,
	input  wire logic [ts_pkg::CFG_DATA_BITS-1:0]   wr_data,
	output ts_pkg::cfg_t                            cfg
);

	ts_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.transient_gain    <= ts_pkg::GAIN_UNITY;
			cfg_q.steady_gain       <= ts_pkg::GAIN_UNITY;
			cfg_q.fast_rise_coeff   <= '0;
			cfg_q.fast_fall_coeff   <= '0;
			cfg_q.slow_smooth_coeff <= '0;
			cfg_q.silence_floor     <= ts_pkg::FLOOR_RESET;
		end else if (wr_en) begin
			case (wr_index)
				ts_pkg::REG_TRANSIENT_GAIN: begin
					cfg_q.transient_gain <= wr_data[ts_pkg::GAIN_BITS-1:0];
				end
				ts_pkg::REG_STEADY_GAIN: begin
					cfg_q.steady_gain <= wr_data[ts_pkg::GAIN_BITS-1:0];
				end
				ts_pkg::REG_FAST_RISE: begin
					cfg_q.fast_rise_coeff <= wr_data[ts_pkg::COEFF_BITS-1:0];
				end
				ts_pkg::REG_FAST_FALL: begin
					cfg_q.fast_fall_coeff <= wr_data[ts_pkg::COEFF_BITS-1:0];
				end
				ts_pkg::REG_SLOW_SMOOTH: begin
					cfg_q.slow_smooth_coeff <= wr_data[ts_pkg::COEFF_BITS-1:0];
				end
				ts_pkg::REG_SILENCE_FLR: begin
					cfg_q.silence_floor <= wr_data[ts_pkg::FLOOR_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== src/ts_ucode_rom.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ts_ucode_rom (
	input  wire logic [ts_pkg::PC_BITS-1:0] pc,
	output ts_pkg::ucode_t                  uword
);

	always_comb begin
		uword = '{ts_pkg::MUL_NONE, ts_pkg::UPD_NONE, 1'b0, 1'b0, '0, ts_pkg::EMIT_NONE};
		case (pc)
			3'd0: begin
				uword.mul = ts_pkg::MUL_FAST;
			end
			3'd1: begin
				uword.upd = ts_pkg::UPD_FAST;
			end
			3'd2: begin
				uword.mul = ts_pkg::MUL_SLOW;
			end
			3'd3: begin
				uword.upd = ts_pkg::UPD_SLOW;
			end
			3'd4: begin
				// at or below the floor skip the gain multiply
				uword.decide    = 1'b1;
				uword.jmp_quiet = 1'b1;
				uword.target    = ts_pkg::STEP_EMIT_PASS;
			end
			3'd5: begin
				uword.mul = ts_pkg::MUL_GAIN;
			end
			3'd6: begin
				uword.emit = ts_pkg::EMIT_GAIN;
			end
			ts_pkg::STEP_EMIT_PASS: begin
				uword.emit = ts_pkg::EMIT_PASS;
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== src/ts_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ts_datapath (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire ts_pkg::dp_ctrl_t                      ctrl,
	input  wire ts_pkg::cfg_t                          cfg,
	input  wire logic signed [ts_pkg::SAMPLE_BITS-1:0] sample_in,
	output logic                                       quiet,
	output logic signed [ts_pkg::SAMPLE_BITS-1:0]      sample_out,
	output logic                                       is_transient
);

	localparam int SB = ts_pkg::SAMPLE_BITS;
	localparam int LB = ts_pkg::LEVEL_BITS;
	localparam int MA = ts_pkg::MUL_A_BITS;
	localparam int MB = ts_pkg::MUL_B_BITS;
	localparam int PW = ts_pkg::PROD_BITS;

	localparam logic signed [PW-1:0] S_MAX = PW'((64'sd1 <<< (SB - 1)) - 64'sd1);
	localparam logic signed [PW-1:0] S_MIN = ~S_MAX;
	localparam logic signed [PW-1:0] ROUND = PW'(64'sd1 <<< (ts_pkg::GAIN_FRAC - 1));

	logic signed [SB-1:0] s_q;
	logic [LB-1:0]        mag_q;
	logic [LB-1:0]        fast_q;
	logic [LB-1:0]        slow_q;
	logic signed [PW-1:0] prod_q;
	logic [MB-1:0]        gain_q;
	logic                 trans_q;
	logic signed [SB-1:0] sample_out_q;
	logic                 is_transient_q;

	logic [SB-1:0]        abs_s;
	logic [LB-1:0]        mag_d;
	logic signed [MA-1:0] op_a;
	logic [MB-1:0]        op_b;
	logic signed [PW-1:0] prod_d;
	logic signed [PW-1:0] step_d;
	logic [LB-1:0]        level_d;
	logic [LB-1:0]        floor_ext;
	logic signed [PW-1:0] scaled;
	logic signed [SB-1:0] sat_d;

	assign abs_s = sample_in[SB-1] ? SB'(-sample_in) : SB'(sample_in);
	assign mag_d = LB'(abs_s) << ts_pkg::LEVEL_SHIFT;

	always_comb begin
		op_a = '0;
		op_b = '0;
		case (ctrl.mul)
			ts_pkg::MUL_FAST: begin
				op_a = $signed({1'b0, fast_q}) - $signed({1'b0, mag_q});
				op_b = (mag_q > fast_q) ? MB'(cfg.fast_rise_coeff) : MB'(cfg.fast_fall_coeff);
			end
			ts_pkg::MUL_SLOW: begin
				op_a = $signed({1'b0, slow_q}) - $signed({1'b0, mag_q});
				op_b = MB'(cfg.slow_smooth_coeff);
			end
			ts_pkg::MUL_GAIN: begin
				op_a = MA'(s_q);
				op_b = gain_q;
			end
			default: begin
			end
		endcase
	end

	// level' = mag + floor(c * (level - mag) / 2^coeff_bits)
	assign prod_d  = PW'(op_a * $signed({1'b0, op_b}));
	assign step_d  = prod_q >>> ts_pkg::COEFF_BITS;
	assign level_d = mag_q + step_d[LB-1:0];

	assign floor_ext = LB'(cfg.silence_floor) << ts_pkg::LEVEL_SHIFT;
	assign quiet     = !(slow_q > floor_ext);

	assign scaled = (prod_q + ROUND) >>> ts_pkg::GAIN_FRAC;

	always_comb begin
		if (scaled > S_MAX) begin
			sat_d = S_MAX[SB-1:0];
		end else if (scaled < S_MIN) begin
			sat_d = S_MIN[SB-1:0];
		end else begin
			sat_d = scaled[SB-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fast_q <= '0;
			slow_q <= '0;
		end else begin
			case (ctrl.upd)
				ts_pkg::UPD_FAST: begin
					fast_q <= level_d;
				end
				ts_pkg::UPD_SLOW: begin
					slow_q <= level_d;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			s_q   <= sample_in;
			mag_q <= mag_d;
		end
		if (ctrl.mul != ts_pkg::MUL_NONE) begin
			prod_q <= prod_d;
		end
		if (ctrl.decide) begin
			trans_q <= fast_q > slow_q;
			gain_q  <= (fast_q > slow_q) ? MB'(cfg.transient_gain) : MB'(cfg.steady_gain);
		end
		case (ctrl.emit)
			ts_pkg::EMIT_GAIN: begin
				sample_out_q   <= sat_d;
				is_transient_q <= trans_q;
			end
			ts_pkg::EMIT_PASS: begin
				sample_out_q   <= s_q;
				is_transient_q <= 1'b0;
			end
			default: begin
			end
		endcase
	end

	assign sample_out   = sample_out_q;
	assign is_transient = is_transient_q;

endmodule

`default_nettype wire

// ===== src/transient_shaper_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Dual-envelope transient shaper, one signed Q1.23 sample per item and one
// result per item. A microcode sequencer steps a single shared multiplier
// through the fast follower, the slow follower and the gain multiply; when
// the slow envelope is not above the silence floor the gain multiply is
// skipped and the sample passes unchanged. The next item can be taken in
// the cycle after the result is loaded, so items do not overlap. in_stall
// is high while an item is in work; a finished result waits in the output
// register, so the next item is taken while it is still stalled, and that
// item holds at its last step until the register is free. The configuration
// port is always ready; registers should only be written while no item is
// in work. Reset clears both envelopes and loads unity gains, zero
// coefficients and a silence floor of 8.
module transient_shaper_top (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  in_valid,
	output logic                                       in_stall,
	input  wire logic signed [ts_pkg::SAMPLE_BITS-1:0] sample_in,
	output logic                                       out_valid,
	input  wire logic                                  out_stall,
	output logic signed [ts_pkg::SAMPLE_BITS-1:0]      sample_out,
	output logic                                       is_transient,
	input  wire logic                                  cfg_valid,
	output logic                                       cfg_ready,
	input  wire logic [ts_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
	input  wire logic [ts_pkg::CFG_DATA_BITS-1:0]      cfg_data
);

	ts_pkg::cfg_t      cfg;
	ts_pkg::ucode_t    uword;
	ts_pkg::dp_ctrl_t  ctrl;

	logic                       busy_q;
	logic [ts_pkg::PC_BITS-1:0] pc_q;
	logic                       out_valid_q;
	logic                       quiet;
	logic                       accept;
	logic                       emit_ok;
	logic                       emit_fire;

	assign cfg_ready = 1'b1;

	ts_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	ts_ucode_rom u_rom (
		.pc    (pc_q),
		.uword (uword)
	);

	assign accept    = in_valid && !busy_q;
	assign emit_ok   = !(out_valid_q && out_stall);
	assign emit_fire = busy_q && (uword.emit != ts_pkg::EMIT_NONE) && emit_ok;

	always_comb begin
		ctrl.load   = accept;
		ctrl.mul    = busy_q ? uword.mul : ts_pkg::MUL_NONE;
		ctrl.upd    = busy_q ? uword.upd : ts_pkg::UPD_NONE;
		ctrl.decide = busy_q && uword.decide;
		ctrl.emit   = emit_fire ? uword.emit : ts_pkg::EMIT_NONE;
	end

	ts_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.cfg          (cfg),
		.sample_in    (sample_in),
		.quiet        (quiet),
		.sample_out   (sample_out),
		.is_transient (is_transient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			pc_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit_fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (accept) begin
				busy_q <= 1'b1;
				pc_q   <= '0;
			end else if (busy_q) begin
				if (uword.emit != ts_pkg::EMIT_NONE) begin
					if (emit_ok) begin
						busy_q <= 1'b0;
					end
				end else if (uword.jmp_quiet && quiet) begin
					pc_q <= uword.target;
				end else begin
					pc_q <= pc_q + 1'b1;
				end
			end
		end
	end

	assign in_stall  = busy_q;
	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	a_accept_busies: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("accepted item did not start the sequencer");

	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(busy_q))
		else $error("result appeared with no item in work");

	a_emit_releases: assert property (@(posedge clk) disable iff (!arst_n)
		emit_fire |=> (!busy_q && out_valid))
		else $error("emit step did not release the sequencer");
`endif

endmodule

`default_nettype wire
